// ----- hw/rtl/pvbb_pkg.sv -----
`timescale 1ns / 1ps

package pvbb_pkg;

   localparam int COORD_W = 32;
   localparam int PROD_W  = 2 * COORD_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int FRAC_W  = 16;
   localparam int CSR_W   = 3;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [COORD_W-1:0] COEF_ONE  = 32'sh0001_0000;
   localparam logic [COORD_W-1:0]        HALF_LSB  = 32'h8000_0000;

   typedef enum logic [CSR_W-1:0] {
      CSR_ROW0_X      = 3'd0,
      CSR_ROW0_Y      = 3'd1,
      CSR_ROW0_Z      = 3'd2,
      CSR_ROW0_OFFSET = 3'd3,
      CSR_ROW1_X      = 3'd4,
      CSR_ROW1_Y      = 3'd5,
      CSR_ROW1_Z      = 3'd6,
      CSR_ROW1_OFFSET = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] offset;
   } row_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

   typedef struct packed {
      logic valid;
      logic last;
   } stage_type;

   localparam row_type ROW0_RESET = '{x: COEF_ONE, y: '0, z: '0, offset: '0};
   localparam row_type ROW1_RESET = '{x: '0, y: COEF_ONE, z: '0, offset: '0};

   // Round a Q32.32 sum to the nearest integer, ties to even, then saturate.
   function automatic logic signed [COORD_W-1:0] round_sat(
      input logic signed [SUM_W-1:0] s
   );
      logic signed [SUM_W-COORD_W:0] hi;
      logic [COORD_W-1:0]            lo;
      logic signed [COORD_W-1:0]     res;
      hi = {s[SUM_W-1], s[SUM_W-1:COORD_W]};
      lo = s[COORD_W-1:0];
      if (lo > HALF_LSB) begin
         hi = hi + (SUM_W-COORD_W+1)'(1);
      end else if (lo == HALF_LSB) begin
         hi = hi + {{(SUM_W-COORD_W){1'b0}}, hi[0]};
      end
      if (hi[SUM_W-COORD_W:COORD_W-1] == '0 || hi[SUM_W-COORD_W:COORD_W-1] == '1) begin
         res = hi[COORD_W-1:0];
      end else if (hi[SUM_W-COORD_W]) begin
         res = COORD_MIN;
      end else begin
         res = COORD_MAX;
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/project_vertices_bounding_box.sv -----
`timescale 1ns / 1ps

// Screen bounding box of projected vertices. One vertex word is taken per
// cycle; each is mapped by two affine rows (Q16.16 coefficients, exact Q32.32
// sum, round half to even, saturate to 32 bits) and folded into a running
// min/max box. The word flagged last_vertex closes the group: its box word
// reaches rsp_ once the vertex has passed the stages below, and the box clears.
// The pipeline is input register, product register (three 32x32 multipliers
// per row), rounded-coordinate register, then the box/result register. Only
// a last vertex that finds the result word still waiting holds the pipeline;
// other vertices keep flowing. Write the csr_ registers only while idle.
module project_vertices_bounding_box (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [pvbb_pkg::COORD_W-1:0] req_vert_x,
   input  logic signed [pvbb_pkg::COORD_W-1:0] req_vert_y,
   input  logic signed [pvbb_pkg::COORD_W-1:0] req_vert_z,
   input  logic                               req_last_vertex,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [pvbb_pkg::COORD_W-1:0] rsp_box_left,
   output logic signed [pvbb_pkg::COORD_W-1:0] rsp_box_top,
   output logic signed [pvbb_pkg::COORD_W-1:0] rsp_box_right,
   output logic signed [pvbb_pkg::COORD_W-1:0] rsp_box_bottom,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pvbb_pkg::CSR_W-1:0]         csr_index,
   input  logic [pvbb_pkg::COORD_W-1:0]       csr_data
);
   import pvbb_pkg::*;

   row_type   row0_ff, row1_ff;
   stage_type s1_ff, s2_ff, s3_ff;
   logic signed [COORD_W-1:0] vx_ff, vy_ff, vz_ff;
   logic      rdy1, rdy2, rdy3;
   logic signed [COORD_W-1:0] pt_x, pt_y;
   point_type pt;
   logic      box_ready;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff <= ROW0_RESET;
         row1_ff <= ROW1_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW0_X:      row0_ff.x      <= csr_data;
            CSR_ROW0_Y:      row0_ff.y      <= csr_data;
            CSR_ROW0_Z:      row0_ff.z      <= csr_data;
            CSR_ROW0_OFFSET: row0_ff.offset <= csr_data;
            CSR_ROW1_X:      row1_ff.x      <= csr_data;
            CSR_ROW1_Y:      row1_ff.y      <= csr_data;
            CSR_ROW1_Z:      row1_ff.z      <= csr_data;
            CSR_ROW1_OFFSET: row1_ff.offset <= csr_data;
            default: ;
         endcase
      end
   end

   // a stage advances when the one after it is empty or moving
   assign rdy2      = !s2_ff.valid || rdy3;
   assign rdy1      = !s1_ff.valid || rdy2;
   assign req_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
      end else begin
         if (rdy1) begin
            s1_ff <= '{valid: req_valid, last: req_last_vertex};
         end
         if (rdy2) begin
            s2_ff <= s1_ff;
         end
         if (rdy3) begin
            s3_ff <= s2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         vx_ff <= req_vert_x;
         vy_ff <= req_vert_y;
         vz_ff <= req_vert_z;
      end
   end

   pvbb_row u_row_x (
      .clock   (clock),
      .prod_en (rdy2),
      .sum_en  (rdy3),
      .vert_x  (vx_ff),
      .vert_y  (vy_ff),
      .vert_z  (vz_ff),
      .coef    (row0_ff),
      .coord   (pt_x)
   );

   pvbb_row u_row_y (
      .clock   (clock),
      .prod_en (rdy2),
      .sum_en  (rdy3),
      .vert_x  (vx_ff),
      .vert_y  (vy_ff),
      .vert_z  (vz_ff),
      .coef    (row1_ff),
      .coord   (pt_y)
   );

   assign pt = '{x: pt_x, y: pt_y};

   pvbb_box u_box (
      .clock          (clock),
      .reset          (reset),
      .pt_stage       (s3_ff),
      .pt             (pt),
      .pt_ready       (box_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_box_left   (rsp_box_left),
      .rsp_box_top    (rsp_box_top),
      .rsp_box_right  (rsp_box_right),
      .rsp_box_bottom (rsp_box_bottom)
   );

   assign rdy3 = !s3_ff.valid || box_ready;

endmodule

// ----- hw/rtl/pvbb_row.sv -----
`timescale 1ns / 1ps

module pvbb_row (
   input  logic                               clock,
   input  logic                               prod_en,
   input  logic                               sum_en,
   input  logic signed [pvbb_pkg::COORD_W-1:0] vert_x,
   input  logic signed [pvbb_pkg::COORD_W-1:0] vert_y,
   input  logic signed [pvbb_pkg::COORD_W-1:0] vert_z,
   input  pvbb_pkg::row_type                  coef,
   output logic signed [pvbb_pkg::COORD_W-1:0] coord
);
   import pvbb_pkg::*;

   logic signed [PROD_W-1:0]  prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [PROD_W-1:0]  prod_x_in, prod_y_in, prod_z_in;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   offset_wide;
   logic signed [COORD_W-1:0] coord_ff, coord_in;

   assign prod_x_in = vert_x * coef.x;
   assign prod_y_in = vert_y * coef.y;
   assign prod_z_in = vert_z * coef.z;

   // Offset is Q16.16: widen and move it up to Q32.32.
   assign offset_wide = SUM_W'(coef.offset) <<< FRAC_W;
   assign sum = SUM_W'(prod_x_ff) + SUM_W'(prod_y_ff) + SUM_W'(prod_z_ff) + offset_wide;
   assign coord_in = round_sat(sum);

   always_ff @(posedge clock) begin
      if (prod_en) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
      end
      if (sum_en) begin
         coord_ff <= coord_in;
      end
   end

   assign coord = coord_ff;

endmodule

// ----- hw/rtl/pvbb_box.sv -----
`timescale 1ns / 1ps

module pvbb_box (
   input  logic                               clock,
   input  logic                               reset,
   input  pvbb_pkg::stage_type                pt_stage,
   input  pvbb_pkg::point_type                pt,
   output logic                               pt_ready,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [pvbb_pkg::COORD_W-1:0] rsp_box_left,
   output logic signed [pvbb_pkg::COORD_W-1:0] rsp_box_top,
   output logic signed [pvbb_pkg::COORD_W-1:0] rsp_box_right,
   output logic signed [pvbb_pkg::COORD_W-1:0] rsp_box_bottom
);
   import pvbb_pkg::*;

   logic signed [COORD_W-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic signed [COORD_W-1:0] min_x_in, max_x_in, min_y_in, max_y_in;
   logic signed [COORD_W-1:0] left_ff, top_ff, right_ff, bottom_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      take;
   logic                      emit;

   // Only a last vertex needs the result register free.
   assign pt_ready = !pt_stage.last || !rsp_valid_ff || rsp_ready;
   assign take     = pt_stage.valid && pt_ready;
   assign emit     = take && pt_stage.last;

   assign min_x_in = (pt.x < min_x_ff) ? pt.x : min_x_ff;
   assign max_x_in = (pt.x > max_x_ff) ? pt.x : max_x_ff;
   assign min_y_in = (pt.y < min_y_ff) ? pt.y : min_y_ff;
   assign max_y_in = (pt.y > max_y_ff) ? pt.y : max_y_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         min_x_ff     <= COORD_MAX;
         min_y_ff     <= COORD_MAX;
         max_x_ff     <= COORD_MIN;
         max_y_ff     <= COORD_MIN;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (emit) begin
            // drop back to the empty box for the next group
            min_x_ff <= COORD_MAX;
            min_y_ff <= COORD_MAX;
            max_x_ff <= COORD_MIN;
            max_y_ff <= COORD_MIN;
         end else if (take) begin
            min_x_ff <= min_x_in;
            min_y_ff <= min_y_in;
            max_x_ff <= max_x_in;
            max_y_ff <= max_y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         left_ff   <= min_x_in;
         top_ff    <= min_y_in;
         right_ff  <= max_x_in;
         bottom_ff <= max_y_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_box_left   = left_ff;
   assign rsp_box_top    = top_ff;
   assign rsp_box_right  = right_ff;
   assign rsp_box_bottom = bottom_ff;

endmodule

// ----- tb/sv/screen_box_checker.sv -----
`timescale 1ns / 1ps

module screen_box_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [pvbb_pkg::COORD_W-1:0] req_vert_x,
   input  logic signed [pvbb_pkg::COORD_W-1:0] req_vert_y,
   input  logic signed [pvbb_pkg::COORD_W-1:0] req_vert_z,
   input  logic                                req_last_vertex,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [pvbb_pkg::COORD_W-1:0] rsp_box_left,
   input  logic signed [pvbb_pkg::COORD_W-1:0] rsp_box_top,
   input  logic signed [pvbb_pkg::COORD_W-1:0] rsp_box_right,
   input  logic signed [pvbb_pkg::COORD_W-1:0] rsp_box_bottom,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [pvbb_pkg::CSR_W-1:0]          csr_index,
   input  logic [pvbb_pkg::COORD_W-1:0]        csr_data,
   output int                                  fail_count,
   output int                                  pending,
   output int                                  boxes_checked
);
   import pvbb_pkg::*;

   localparam int            ACC_W     = 80;
   localparam logic [31:0]   HALF_UNIT = 32'h8000_0000;
   localparam int            MAX_SHOWN = 10;

   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic signed [COORD_W-1:0] right;
      logic signed [COORD_W-1:0] bottom;
   } box_type;

   row_type                   row0, row1;
   logic signed [COORD_W-1:0] min_x, max_x, min_y, max_y;
   box_type                   expected_boxes[$];
   int                        errors = 0;
   int                        boxes = 0;

   // Exact affine sum in Q32.32, rounded half to even, clamped to 32 bits.
   function automatic logic signed [COORD_W-1:0] screen_coord(
      input logic signed [COORD_W-1:0] vx,
      input logic signed [COORD_W-1:0] vy,
      input logic signed [COORD_W-1:0] vz,
      input row_type                   row
   );
      logic signed [ACC_W-1:0] ax, ay, az, cx, cy, cz, off, acc;
      logic signed [47:0]      whole;
      logic [31:0]             frac;
      ax = vx;
      ay = vy;
      az = vz;
      cx = $signed(row.x);
      cy = $signed(row.y);
      cz = $signed(row.z);
      off = $signed(row.offset);
      acc = ax * cx + ay * cy + az * cz + (off <<< 16);
      whole = acc[ACC_W-1:32];
      frac = acc[31:0];
      if (frac > HALF_UNIT || (frac == HALF_UNIT && whole[0])) begin
         whole = whole + 48'sd1;
      end
      if (whole > 48'sh0000_7fff_ffff) begin
         return COORD_MAX;
      end
      if (whole < -48'sh0000_8000_0000) begin
         return COORD_MIN;
      end
      return whole[COORD_W-1:0];
   endfunction

   task automatic flag_field(input string field, input logic signed [COORD_W-1:0] want,
                             input logic signed [COORD_W-1:0] got);
      errors++;
      if (errors <= MAX_SHOWN) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
      end
   endtask

   task automatic clear_box();
      min_x = COORD_MAX;
      min_y = COORD_MAX;
      max_x = COORD_MIN;
      max_y = COORD_MIN;
   endtask

   always @(posedge clock) begin
      box_type                   seen, want;
      logic signed [COORD_W-1:0] sx, sy;
      if (reset) begin
         row0 = ROW0_RESET;
         row1 = ROW1_RESET;
         expected_boxes.delete();
         clear_box();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROW0_X:      row0.x = csr_data;
               CSR_ROW0_Y:      row0.y = csr_data;
               CSR_ROW0_Z:      row0.z = csr_data;
               CSR_ROW0_OFFSET: row0.offset = csr_data;
               CSR_ROW1_X:      row1.x = csr_data;
               CSR_ROW1_Y:      row1.y = csr_data;
               CSR_ROW1_Z:      row1.z = csr_data;
               CSR_ROW1_OFFSET: row1.offset = csr_data;
               default: ;
            endcase
         end
         // Match outgoing words before folding in this edge's vertex.
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_box_left, rsp_box_top, rsp_box_right, rsp_box_bottom};
            if (expected_boxes.size() == 0) begin
               errors++;
               if (errors <= MAX_SHOWN) begin
                  $display("%0t: unexpected box word %0d %0d %0d %0d", $realtime,
                           seen.left, seen.top, seen.right, seen.bottom);
               end
            end else begin
               want = expected_boxes.pop_front();
               boxes++;
               if (seen.left != want.left) flag_field("box_left", want.left, seen.left);
               if (seen.top != want.top) flag_field("box_top", want.top, seen.top);
               if (seen.right != want.right) flag_field("box_right", want.right, seen.right);
               if (seen.bottom != want.bottom) begin
                  flag_field("box_bottom", want.bottom, seen.bottom);
               end
            end
         end
         if (req_valid && req_ready) begin
            sx = screen_coord(req_vert_x, req_vert_y, req_vert_z, row0);
            sy = screen_coord(req_vert_x, req_vert_y, req_vert_z, row1);
            if (sx < min_x) min_x = sx;
            if (sx > max_x) max_x = sx;
            if (sy < min_y) min_y = sy;
            if (sy > max_y) max_y = sy;
            if (req_last_vertex) begin
               expected_boxes.push_back('{min_x, min_y, max_x, max_y});
               clear_box();
            end
         end
      end
      fail_count <= errors;
      pending <= expected_boxes.size();
      boxes_checked <= boxes;
   end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import pvbb_pkg::*;

   typedef enum {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} flow_type;
   typedef enum {ROWS_MODERATE, ROWS_FULL, ROWS_HIGH, ROWS_LOW, ROWS_TIES} rows_type;

   localparam int NUM_PHASES     = 8;
   localparam int PHASE_VERTICES = 50;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 8;

   localparam flow_type FLOW_PLAN[NUM_PHASES] = '{
      FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH,
      FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH
   };
   localparam rows_type ROWS_PLAN[NUM_PHASES] = '{
      ROWS_MODERATE, ROWS_HIGH, ROWS_FULL, ROWS_TIES,
      ROWS_LOW, ROWS_MODERATE, ROWS_FULL, ROWS_MODERATE
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_vert_x = '0;
   logic signed [COORD_W-1:0] req_vert_y = '0;
   logic signed [COORD_W-1:0] req_vert_z = '0;
   logic                      req_last_vertex = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [COORD_W-1:0] rsp_box_left, rsp_box_top, rsp_box_right, rsp_box_bottom;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   csr_index_type             csr_index = CSR_ROW0_X;
   logic [COORD_W-1:0]        csr_data = '0;

   int fail_count, pending, boxes_checked;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int vertices_sent = 0;
   int groups_sent = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   project_vertices_bounding_box uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_vert_x     (req_vert_x),
      .req_vert_y     (req_vert_y),
      .req_vert_z     (req_vert_z),
      .req_last_vertex(req_last_vertex),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_box_left   (rsp_box_left),
      .rsp_box_top    (rsp_box_top),
      .rsp_box_right  (rsp_box_right),
      .rsp_box_bottom (rsp_box_bottom),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   screen_box_checker box_watch (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_vert_x     (req_vert_x),
      .req_vert_y     (req_vert_y),
      .req_vert_z     (req_vert_z),
      .req_last_vertex(req_last_vertex),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_box_left   (rsp_box_left),
      .rsp_box_top    (rsp_box_top),
      .rsp_box_right  (rsp_box_right),
      .rsp_box_bottom (rsp_box_bottom),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .pending        (pending),
      .boxes_checked  (boxes_checked)
   );

   // Result side: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic signed [COORD_W-1:0] random_coord();
      logic signed [COORD_W-1:0] v;
      case ($urandom_range(9))
         0, 1, 2: v = $urandom;
         3: begin
            case ($urandom_range(3))
               0: v = COORD_MAX;
               1: v = COORD_MIN;
               2: v = '0;
               default: v = -1;
            endcase
         end
         4, 5: begin
            // exact half fraction, so identity-like rows land on ties
            v = $signed($urandom) >>> 8;
            v[15:0] = 16'h8000;
         end
         default: v = $signed($urandom) >>> 8;
      endcase
      return v;
   endfunction

   task automatic send_vertex(input logic signed [COORD_W-1:0] vx,
                              input logic signed [COORD_W-1:0] vy,
                              input logic signed [COORD_W-1:0] vz, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vert_x <= vx;
      req_vert_y <= vy;
      req_vert_z <= vz;
      req_last_vertex <= last;
      do @(posedge clock); while (!req_ready);
      vertices_sent++;
      if (last) groups_sent++;
   endtask

   task automatic wait_for_boxes();
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [COORD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_rows(input row_type r0, input row_type r1);
      write_reg(CSR_ROW0_X, r0.x);
      write_reg(CSR_ROW0_Y, r0.y);
      write_reg(CSR_ROW0_Z, r0.z);
      write_reg(CSR_ROW0_OFFSET, r0.offset);
      write_reg(CSR_ROW1_X, r1.x);
      write_reg(CSR_ROW1_Y, r1.y);
      write_reg(CSR_ROW1_Z, r1.z);
      write_reg(CSR_ROW1_OFFSET, r1.offset);
      csr_valid <= 1'b0;
   endtask

   task automatic pick_rows(input rows_type kind, output row_type r0, output row_type r1);
      case (kind)
         ROWS_MODERATE: begin
            r0.x = $signed($urandom) >>> 13;
            r0.y = $signed($urandom) >>> 13;
            r0.z = $signed($urandom) >>> 13;
            r0.offset = $signed($urandom) >>> 4;
            r1.x = $signed($urandom) >>> 13;
            r1.y = $signed($urandom) >>> 13;
            r1.z = $signed($urandom) >>> 13;
            r1.offset = $signed($urandom) >>> 4;
         end
         ROWS_FULL: begin
            r0 = {$urandom, $urandom, $urandom, $urandom};
            r1 = {$urandom, $urandom, $urandom, $urandom};
         end
         ROWS_HIGH: begin
            r0 = '{x: COORD_MAX, y: COORD_MAX, z: COORD_MAX, offset: COORD_MAX};
            r1 = r0;
         end
         ROWS_LOW: begin
            r0 = '{x: COORD_MIN, y: COORD_MIN, z: COORD_MIN, offset: COORD_MIN};
            r1 = r0;
         end
         default: begin
            // x plus a half offset, and half of y: both can produce ties
            r0 = '{x: COEF_ONE, y: '0, z: '0, offset: 32'sh0000_8000};
            r1 = '{x: '0, y: 32'sh0000_8000, z: '0, offset: '0};
         end
      endcase
   endtask

   task automatic run_phase(input flow_type flow, input bit hold, input bit pause);
      int  sent;
      int  len;
      bit  paused;
      sent = 0;
      paused = 1'b0;
      case (flow)
         FLOW_FREE: begin
            send_idle_pct = 0;
            stall_pct <= 0;
         end
         FLOW_SEND_IDLE: begin
            send_idle_pct = 58;
            stall_pct <= 0;
         end
         FLOW_RECV_STALL: begin
            send_idle_pct = 0;
            stall_pct <= 58;
         end
         default: begin
            send_idle_pct = 33;
            stall_pct <= 33;
         end
      endcase
      // one-vertex groups behind a stalled receiver fill the pipe
      if (hold) hold_req <= hold_req + 1;
      while (sent < PHASE_VERTICES) begin
         if (hold) len = 1;
         else if ($urandom_range(9) == 0) len = $urandom_range(40, 8);
         else len = $urandom_range(6, 1);
         for (int k = 0; k < len; k++) begin
            send_vertex(random_coord(), random_coord(), random_coord(), k == len - 1);
         end
         sent += len;
         if (pause && !paused && sent >= PHASE_VERTICES / 2) begin
            req_valid <= 1'b0;
            wait_for_boxes();
            paused = 1'b1;
         end
      end
      req_valid <= 1'b0;
      wait_for_boxes();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      row_type r0, r1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset rows map a vertex straight to its rounded x and y.
      send_vertex('0, '0, '0, 1'b1);
      send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
      send_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
      send_vertex(32'sh0000_8000, 32'shffff_8000, '0, 1'b0);
      send_vertex(32'sh0001_8000, 32'shfffe_8000, '0, 1'b0);
      send_vertex(32'sh0002_8000, 32'sh0001_8000, -1, 1'b1);
      send_vertex(32'sh0000_8001, 32'sh0000_7fff, '0, 1'b0);
      send_vertex(32'shffff_7fff, 32'shffff_8001, '0, 1'b1);
      send_vertex(32'shffff_0000, COEF_ONE, 32'sh1234_5678, 1'b1);
      send_vertex(-1, 1, COORD_MAX, 1'b0);
      send_vertex(32'sh7fff_8000, 32'sh8000_8000, COORD_MIN, 1'b1);
      req_valid <= 1'b0;
      wait_for_boxes();
      repeat (DRAIN_CYCLES) @(posedge clock);

      for (int p = 0; p < NUM_PHASES; p++) begin
         pick_rows(ROWS_PLAN[p], r0, r1);
         program_rows(r0, r1);
         if (ROWS_PLAN[p] == ROWS_HIGH) begin
            // drive both rows into saturation, one group
            send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
            send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
            send_vertex(1, '0, '0, 1'b0);
            send_vertex('0, '0, '0, 1'b1);
         end
         run_phase(FLOW_PLAN[p], FLOW_PLAN[p] == FLOW_FREE && p > 0, p == 2);
      end

      wait_for_boxes();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d vertices in %0d groups and checked %0d boxes under %0d row settings,",
               vertices_sent, groups_sent, boxes_checked, NUM_PHASES + 1);
      $display("with free, sender-idle, receiver-stall and mixed handshakes plus a long hold-off.");
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- project_vertices_bounding_box.f -----
hw/rtl/pvbb_pkg.sv
hw/rtl/pvbb_row.sv
hw/rtl/pvbb_box.sv
hw/rtl/project_vertices_bounding_box.sv
tb/sv/screen_box_checker.sv
tb/sv/testbench.sv
